[hw/rtl/integer_to_ascii_digits_macros.svh]
`ifndef INTEGER_TO_ASCII_DIGITS_MACROS_SVH
`define INTEGER_TO_ASCII_DIGITS_MACROS_SVH

// same-cycle implication, disabled during reset
`define I2A_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2a assertion failed");

// next-cycle implication, disabled during reset
`define I2A_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2a assertion failed");

`endif

[hw/rtl/i2a_pkg.sv]
`timescale 1ns / 1ps

package i2a_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int MAX_RADIX_DEF   = 16;
    localparam int VALUE_W         = 64;
    localparam int RADIX_W         = 5;
    localparam int CHAR_W          = 7;
    localparam int COUNT_W         = 7;
    localparam int DIGIT_W         = 4;
    localparam int DIV_STEP        = 8;
    localparam int QUEUE_DEPTH     = 2;
    localparam int NUM_GLYPHS      = 16;

    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 7'h7a;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 7'h20;

    localparam logic [CHAR_W-1:0] GLYPHS [NUM_GLYPHS] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        logic               uppercase;
    } item_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  ascii_char;
        logic               is_last;
        logic [COUNT_W-1:0] digit_count;
    } result_t;

    // classified item as held in the queue
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        logic               upper;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d,
                                                input logic upper);
        logic [CHAR_W-1:0] c;
        c = GLYPHS[d];
        if (upper && c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            c = c - CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

[hw/rtl/i2a_front.sv]
`timescale 1ns / 1ps

module i2a_front
    import i2a_pkg::*;
#(
    parameter int MAX_RADIX = MAX_RADIX_DEF
)(
    input  logic        start,
    input  item_t       item,
    input  queue_stat_t q_stat,
    output logic        busy,
    output logic        push,
    output job_t        job
);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(MAX_RADIX);

    assign busy = q_stat.full;
    assign push = start && !q_stat.full;

    // saturate radix into the supported range
    always_comb
    begin
        job.value = item.value;
        job.upper = item.uppercase;
        priority if (item.radix < RADIX_MIN)
        begin
            job.radix = RADIX_MIN;
        end
        else if (item.radix > RADIX_MAX)
        begin
            job.radix = RADIX_MAX;
        end
        else
        begin
            job.radix = item.radix;
        end
    end

endmodule

[hw/rtl/i2a_queue.sv]
`timescale 1ns / 1ps

module i2a_queue
    import i2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  job_t        push_job,
    input  logic        pop,
    output job_t        head,
    output queue_stat_t q_stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hw/rtl/i2a_back.sv]
`timescale 1ns / 1ps

module i2a_back
    import i2a_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        head,
    input  queue_stat_t q_stat,
    output logic        pop,
    output result_t     result,
    output logic        strobe
);

    localparam int DIV_W  = ((VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
    localparam int STEPS  = DIV_W / DIV_STEP;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int ADDR_W = $clog2(VALUE_WIDTH);
    localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    // eight restoring steps, remainder always below the radix
    function automatic logic [DIV_STEP+DIGIT_W-1:0] div_step(
        input logic [DIGIT_W-1:0]  rem,
        input logic [DIV_STEP-1:0] bits,
        input logic [RADIX_W-1:0]  radix
    );
        logic [DIGIT_W:0]    r;
        logic [DIV_STEP-1:0] q;
        r = {1'b0, rem};
        q = '0;
        for (int i = DIV_STEP - 1; i >= 0; i--)
        begin
            r = {r[DIGIT_W-1:0], bits[i]};
            if (r >= radix)
            begin
                r    = r - radix;
                q[i] = 1'b1;
            end
        end
        return {q, r[DIGIT_W-1:0]};
    endfunction

    logic [DIGIT_W-1:0] digit_mem [VALUE_WIDTH];

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [ADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               rd_last_reg, rd_last_next;
    logic               strobe_reg, strobe_next;

    logic [DIV_W-1:0]   work_reg, work_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic               upper_reg, upper_next;
    logic [DIGIT_W-1:0] rd_data_reg;
    result_t            result_reg, result_next;

    logic [DIV_STEP-1:0] q_bits;
    logic [DIGIT_W-1:0]  rem_new;
    logic [DIV_W-1:0]    work_new;
    logic                wr_en;

    assign {q_bits, rem_new} = div_step(rem_reg, work_reg[DIV_W-1 -: DIV_STEP], radix_reg);
    assign work_new = (work_reg << DIV_STEP) | DIV_W'(q_bits);
    assign wr_en    = (state_reg == S_DIV) && (step_reg == LAST_STEP);
    assign pop      = (state_reg == S_IDLE) && !q_stat.empty;

    assign result = result_reg;
    assign strobe = strobe_reg;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        n_next       = n_reg;
        rd_ptr_next  = rd_ptr_reg;
        rd_pend_next = 1'b0;
        rd_last_next = rd_last_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        radix_next   = radix_reg;
        upper_next   = upper_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    work_next  = DIV_W'(head.value[VALUE_WIDTH-1:0]);
                    rem_next   = '0;
                    radix_next = head.radix;
                    upper_next = head.upper;
                    step_next  = '0;
                    n_next     = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                work_next = work_new;
                if (step_reg == LAST_STEP)
                begin
                    step_next = '0;
                    rem_next  = '0;
                    n_next    = n_reg + CNT_W'(1);
                    if (work_new == '0)
                    begin
                        rd_ptr_next = n_reg[ADDR_W-1:0];
                        state_next  = S_EMIT;
                    end
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                    rem_next  = rem_new;
                end
            end
            S_EMIT:
            begin
                rd_pend_next = 1'b1;
                rd_last_next = (rd_ptr_reg == '0);
                if (rd_ptr_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_ptr_next = rd_ptr_reg - ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        strobe_next             = rd_pend_reg;
        result_next.ascii_char  = glyph(rd_data_reg, upper_reg);
        result_next.is_last     = rd_last_reg;
        result_next.digit_count = COUNT_W'(n_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            n_reg       <= '0;
            rd_ptr_reg  <= '0;
            rd_pend_reg <= 1'b0;
            rd_last_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            n_reg       <= n_next;
            rd_ptr_reg  <= rd_ptr_next;
            rd_pend_reg <= rd_pend_next;
            rd_last_reg <= rd_last_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        rem_reg    <= rem_next;
        radix_reg  <= radix_next;
        upper_reg  <= upper_next;
        result_reg <= result_next;
    end

    // digit store, least significant digit at address zero
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            digit_mem[n_reg[ADDR_W-1:0]] <= rem_new;
        end
        if (state_reg == S_EMIT)
        begin
            rd_data_reg <= digit_mem[rd_ptr_reg];
        end
    end

endmodule

[hw/rtl/integer_to_ascii_digits.sv]
`timescale 1ns / 1ps

// integer to ascii digits: takes an unsigned value, a radix (saturated into
// 2..MAX_RADIX) and an uppercase flag, and emits the digits as ascii
// characters, most significant first, no leading zeros, one beat per cycle
// on result with strobe high; every beat carries the digit count and the
// last one has is_last set. the receiver cannot stall, so beats of one
// number always come on consecutive cycles. an item is taken when start is
// high and busy is low; busy is high only while the two-entry queue is full.
// per item: the divider makes 8 quotient bits per cycle and writes one digit
// into the digit store each time a pass over the value ends; when the value
// reaches zero the digits are emitted, most significant first. the divide
// loop sets the time per item; the queue lets the next items be accepted
// meanwhile.
module integer_to_ascii_digits
    import i2a_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int MAX_RADIX   = MAX_RADIX_DEF
)(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output result_t result,
    output logic    strobe
);

    // queue status shared by front and back
    queue_stat_t q_stat;
    job_t        push_job;
    job_t        head;
    logic        push;
    logic        pop;

    // front: handshake and radix saturation
    i2a_front #(
        .MAX_RADIX (MAX_RADIX)
    ) u_front (
        .start  (start),
        .item   (item),
        .q_stat (q_stat),
        .busy   (busy),
        .push   (push),
        .job    (push_job)
    );

    // short queue between classification and conversion
    i2a_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    // back: repeated division into the digit store, then emission
    i2a_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .result (result),
        .strobe (strobe)
    );

endmodule

[hw/rtl/i2a_checker.sv]
`timescale 1ns / 1ps
`include "integer_to_ascii_digits_macros.svh"

module i2a_checker
    import i2a_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input result_t result,
    input logic    strobe
);

    // characters are digits or hex letters of either case
    `I2A_ASSERT_IMPLY(a_char_range, clk, rst_n, strobe,
        ((result.ascii_char >= 7'h30 && result.ascii_char <= 7'h39) ||
         (result.ascii_char >= 7'h61 && result.ascii_char <= 7'h66) ||
         (result.ascii_char >= 7'h41 && result.ascii_char <= 7'h46)))

    `I2A_ASSERT_IMPLY(a_count_range, clk, rst_n, strobe,
        (result.digit_count != 7'd0 && result.digit_count <= 7'd64))

    // beats of one number are back to back
    `I2A_ASSERT_NEXT(a_beats_contiguous, clk, rst_n, strobe && !result.is_last, strobe)

    `I2A_ASSERT_NEXT(a_count_steady, clk, rst_n, strobe && !result.is_last,
        $stable(result.digit_count))

endmodule

bind integer_to_ascii_digits i2a_checker u_i2a_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .result (result),
    .strobe (strobe)
);

[test/ascii_digit_checker.sv]
`timescale 1ns / 1ps

module ascii_digit_checker
    import i2a_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  item_t   item,
    input  result_t result,
    input  logic    strobe,
    output int      fail_count,
    output int      beats_waiting
);

    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;

    result_t due_chars[$];
    int      error_count = 0;

    assign fail_count = error_count;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("checker: %s got %0h want %0h", what, got, want);
        error_count++;
    endtask

    function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d,
                                                  input logic upper);
        if (d < 10)
        begin
            return ASCII_ZERO + CHAR_W'(d);
        end
        return (upper ? ASCII_UPPER_A : ASCII_LOWER_A) + CHAR_W'(d) - CHAR_W'(10);
    endfunction

    // divide down to get digits lsd first, then queue them msd first
    task automatic queue_digits(input item_t it);
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] base;
        logic [DIGIT_W-1:0] digits [64];
        int                 n;
        result_t            beat;
        v = it.value;
        if (it.radix < 2)
        begin
            base = VALUE_W'(2);
        end
        else if (it.radix > MAX_RADIX_DEF)
        begin
            base = VALUE_W'(MAX_RADIX_DEF);
        end
        else
        begin
            base = VALUE_W'(it.radix);
        end
        n = 0;
        do
        begin
            digits[n] = DIGIT_W'(v % base);
            n++;
            v = v / base;
        end
        while (v != 0 && n < 64);
        for (int k = 0; k < n; k++)
        begin
            beat.ascii_char  = char_of(digits[n - 1 - k], it.uppercase);
            beat.is_last     = (k == n - 1);
            beat.digit_count = COUNT_W'(n);
            due_chars.push_back(beat);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (strobe === 1'b1)
            begin
                if (due_chars.size() == 0)
                begin
                    report_mismatch("unexpected beat", result, 0);
                end
                else
                begin
                    want = due_chars.pop_front();
                    if (result.ascii_char !== want.ascii_char)
                    begin
                        report_mismatch("ascii_char", result.ascii_char, want.ascii_char);
                    end
                    if (result.is_last !== want.is_last)
                    begin
                        report_mismatch("is_last", result.is_last, want.is_last);
                    end
                    if (result.digit_count !== want.digit_count)
                    begin
                        report_mismatch("digit_count", result.digit_count, want.digit_count);
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                queue_digits(item);
            end
            beats_waiting <= due_chars.size();
        end
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import i2a_pkg::*;

    // generous bound on the whole run; the slowest item is radix 2, 64 digits
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 195;
    // cycles to watch for stray beats once nothing is due
    localparam int DRAIN_CYCLES = 40;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    result_t result;
    logic    strobe;
    int      fail_count;
    int      beats_waiting;
    int      cycle_count = 0;

    always #1 clk = ~clk;

    integer_to_ascii_digits u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .result (result),
        .strobe (strobe)
    );

    // watches both sides, predicts every beat and counts mismatches
    ascii_digit_checker u_digit_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result        (result),
        .strobe        (strobe),
        .fail_count    (fail_count),
        .beats_waiting (beats_waiting)
    );

    // watchdog: a hung block or lost beats end up here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic item_t make_item(input logic [VALUE_W-1:0] v,
                                        input logic [RADIX_W-1:0] r,
                                        input logic up);
        item_t it;
        it.value     = v;
        it.radix     = r;
        it.uppercase = up;
        return it;
    endfunction

    // idle cycles after an item is taken: mostly none or short, now and then long
    function automatic int pick_gap(input bit burst);
        int w;
        if (burst)
        begin
            return 0;
        end
        w = $urandom_range(0, 99);
        if (w < 45)
        begin
            return 0;
        end
        if (w < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (w < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    // mostly legal radixes, the rest out of range to hit saturation
    function automatic logic [RADIX_W-1:0] pick_radix();
        int sel;
        if ($urandom_range(0, 99) < 85)
        begin
            return RADIX_W'($urandom_range(2, 16));
        end
        sel = $urandom_range(0, 16);
        if (sel < 2)
        begin
            return RADIX_W'(sel);
        end
        return RADIX_W'(15 + sel);
    endfunction

    // value mix: random widths, full width, tiny values and digit-count edges
    function automatic logic [VALUE_W-1:0] pick_value(input logic [RADIX_W-1:0] r);
        logic [VALUE_W-1:0] p;
        int                 base;
        int                 steps;
        int                 sel;
        base = (r < 2) ? 2 : (r > 16) ? 16 : int'(r);
        sel  = $urandom_range(0, 9);
        if (sel < 4)
        begin
            return {$urandom, $urandom} >> $urandom_range(0, 63);
        end
        if (sel < 6)
        begin
            return {$urandom, $urandom};
        end
        if (sel == 6)
        begin
            return VALUE_W'($urandom_range(0, 40));
        end
        if (sel < 9)
        begin
            // radix power, or one below it: the count of digits steps here
            p     = VALUE_W'(1);
            steps = $urandom_range(1, 64);
            repeat (steps)
            begin
                if (p <= {VALUE_W{1'b1}} / VALUE_W'(base))
                begin
                    p = p * VALUE_W'(base);
                end
            end
            return p - VALUE_W'($urandom_range(0, 1));
        end
        return ($urandom_range(0, 1) != 0) ? {VALUE_W{1'b1}} : '0;
    endfunction

    // called at a clock edge; holds start until the item is taken, then
    // either keeps start high for the next item or idles with junk on item
    task automatic drive_number(input item_t it, input int gap);
        item_t junk;
        start <= 1'b1;
        item  <= it;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        if (gap > 0)
        begin
            junk.value     = {$urandom, $urandom};
            junk.radix     = RADIX_W'($urandom);
            junk.uppercase = 1'($urandom);
            start <= 1'b0;
            item  <= junk;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [RADIX_W-1:0] r;
        bit                 burst;
        int                 gap;
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, full-scale values, saturation on both sides
        drive_number(make_item('0, 5'd10, 1'b0), pick_gap(0));
        drive_number(make_item('0, 5'd0, 1'b1), pick_gap(0));
        drive_number(make_item({VALUE_W{1'b1}}, 5'd2, 1'b0), pick_gap(0));
        drive_number(make_item({VALUE_W{1'b1}}, 5'd10, 1'b0), pick_gap(0));
        drive_number(make_item({VALUE_W{1'b1}}, 5'd16, 1'b1), pick_gap(0));
        drive_number(make_item({$urandom, $urandom}, 5'd0, 1'b0), pick_gap(0));
        drive_number(make_item({$urandom, $urandom}, 5'd1, 1'b1), pick_gap(0));
        drive_number(make_item({$urandom, $urandom}, 5'd17, 1'b0), pick_gap(0));
        drive_number(make_item({$urandom, $urandom}, 5'd31, 1'b1), pick_gap(0));
        drive_number(make_item(64'd1, 5'd31, 1'b0), pick_gap(0));
        // every legal radix, both letter cases, all sixteen digit values
        for (int b = 2; b <= 16; b++)
        begin
            drive_number(make_item(64'hfedc_ba98_7654_3210, RADIX_W'(b), 1'(b)),
                         pick_gap(0));
        end

        // random part, with stretches of back-to-back items
        burst = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
            begin
                burst = ($urandom_range(0, 2) == 0);
            end
            r   = pick_radix();
            gap = pick_gap(burst);
            if (i == RANDOM_ITEMS - 1 && gap == 0)
            begin
                // lower start after the final item is taken
                gap = 1;
            end
            drive_number(make_item(pick_value(r), r, 1'($urandom)), gap);
        end

        // let every predicted character come out, then watch for strays
        do
        begin
            @(posedge clk);
        end
        while (beats_waiting != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
